FILE: hw/rtl/watch_event_alert_cooldown_core_assert.svh
// Assertion helpers for the RTL of the alert cooldown block, included by weac_seq.
`ifndef WATCH_EVENT_ALERT_COOLDOWN_CORE_ASSERT_SVH
`define WATCH_EVENT_ALERT_COOLDOWN_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define WEAC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("weac assertion failed");
// Condition must never be true outside reset.
`define WEAC_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("weac forbidden condition seen");
`else
`define WEAC_ASSERT(label, clk, rst, prop)
`define WEAC_NEVER(label, clk, rst, cond)
`endif

`endif

FILE: hw/rtl/weac_pkg.sv
package weac_pkg;

  localparam int TIME_W = 32;
  localparam int KEY_W = 8;
  localparam int LIM_W = 16;
  localparam int CNT_W = 8;
  localparam int TABLE_DEPTH_DEF = 32;
  // Watched count above this limit is clamped to it.
  localparam int MAX_WATCHES = 128;

  localparam logic [LIM_W-1:0] COOLDOWN_RST = 16'd60;
  localparam logic [LIM_W-1:0] HOLDOFF_RST = 16'd10;
  localparam logic [TIME_W-1:0] ARM_STAMP_RST = 32'd0;
  localparam logic [CNT_W-1:0] WATCHED_RST = 8'd0;

  typedef enum logic [1:0] {
    REG_COOLDOWN,
    REG_HOLDOFF,
    REG_ARM_STAMP,
    REG_WATCHED
  } reg_index_t;

  typedef struct packed {
    logic [LIM_W-1:0] cooldown;
    logic [LIM_W-1:0] holdoff;
    logic [TIME_W-1:0] arm_stamp;
    logic [CNT_W-1:0] watched;
  } cfg_t;

  typedef struct packed {
    logic key_known;
    logic delete_alert;
    logic open_suppressed;
    logic open_alert;
    logic in_holdoff;
  } res_t;

endpackage

FILE: hw/rtl/weac_ram.sv
module weac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/weac_window_cmp.sv
module weac_window_cmp (
  input  logic [weac_pkg::TIME_W-1:0] a,
  input  logic [weac_pkg::TIME_W-1:0] b,
  input  logic [weac_pkg::LIM_W-1:0]  lim,
  output logic                        in_window
);
  import weac_pkg::*;

  logic [TIME_W-1:0] diff;

  // Elapsed time with wrap, then test against the window length.
  assign diff = a - b;
  assign in_window = diff < TIME_W'(lim);

endmodule

FILE: hw/rtl/weac_seq.sv
`include "watch_event_alert_cooldown_core_assert.svh"

module weac_seq #(
  parameter int TABLE_DEPTH = weac_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  weac_pkg::cfg_t              cfg,
  input  logic                        start,
  input  logic [weac_pkg::TIME_W-1:0] in_time,
  input  logic [weac_pkg::KEY_W-1:0]  in_index,
  input  logic                        in_opened,
  input  logic                        in_deleted,
  output logic                        idle,
  output logic                        res_valid,
  input  logic                        res_ready,
  output weac_pkg::res_t              res
);
  import weac_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = KEY_W + TIME_W;

  typedef enum logic [1:0] {S_IDLE, S_HOLD, S_SCAN, S_DONE} state_t;

  state_t state, state_next;
  logic [TIME_W-1:0] now;
  logic [KEY_W-1:0] key;
  logic opened, deleted;
  logic [AW-1:0] ptr, ptr_next;
  logic [CW-1:0] count, count_next;
  res_t res_next;

  logic we, ins;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata, rdata;
  logic [KEY_W-1:0] rd_key;
  logic [TIME_W-1:0] rd_last;
  logic [TIME_W-1:0] cmp_b;
  logic [LIM_W-1:0] cmp_lim;
  logic cmp_inside;
  logic [KEY_W:0] limit;
  logic known, hit, last_entry, room;

  assign rd_key = rdata[EW-1:TIME_W];
  assign rd_last = rdata[TIME_W-1:0];
  assign wdata = {key, now};

  // One window unit: holdoff test first, then cooldown tests during the scan.
  assign cmp_b = (state == S_HOLD) ? cfg.arm_stamp : rd_last;
  assign cmp_lim = (state == S_HOLD) ? cfg.holdoff : cfg.cooldown;

  weac_window_cmp u_cmp (
    .a         (now),
    .b         (cmp_b),
    .lim       (cmp_lim),
    .in_window (cmp_inside)
  );

  weac_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ptr_next),
    .rdata (rdata)
  );

  assign limit = ({1'b0, cfg.watched} > (KEY_W + 1)'(MAX_WATCHES)) ?
                 (KEY_W + 1)'(MAX_WATCHES) : {1'b0, cfg.watched};
  assign known = {1'b0, key} < limit;
  assign hit = rd_key == key;
  assign last_entry = (CW'(ptr) + CW'(1)) == count;
  assign room = count < CW'(TABLE_DEPTH);

  always_comb begin
    state_next = state;
    ptr_next = ptr;
    res_next = res;
    we = 1'b0;
    waddr = ptr;
    ins = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ptr_next = '0;
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        res_next = '0;
        if (cmp_inside) begin
          res_next.in_holdoff = 1'b1;
          state_next = S_DONE;
        end else begin
          res_next.key_known = known;
          res_next.delete_alert = deleted;
          state_next = S_DONE;
          if (opened && known) begin
            res_next.open_alert = 1'b1;
            if (count == '0) begin
              ins = 1'b1;
            end else begin
              state_next = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_next = S_DONE;
          if (cmp_inside) begin
            res_next.open_alert = 1'b0;
            res_next.open_suppressed = 1'b1;
          end else begin
            we = 1'b1;
          end
        end else if (last_entry) begin
          ins = 1'b1;
          state_next = S_DONE;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    count_next = count;
    if (ins && room) begin
      we = 1'b1;
      waddr = count[AW-1:0];
      count_next = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ptr <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      ptr <= ptr_next;
      count <= count_next;
    end
    res <= res_next;
    if (start) begin
      now <= in_time;
      key <= in_index;
      opened <= in_opened;
      deleted <= in_deleted;
    end
  end

  assign idle = state == S_IDLE;
  assign res_valid = state == S_DONE;

  `WEAC_ASSERT(a_count_bound, clk, rst, count <= CW'(TABLE_DEPTH))
  `WEAC_ASSERT(a_scan_in_table, clk, rst, (state == S_SCAN) |-> (CW'(ptr) < count))
  `WEAC_ASSERT(a_write_when_busy, clk, rst, we |-> (state == S_HOLD || state == S_SCAN))
  `WEAC_NEVER(a_holdoff_alone, clk, rst,
              res_valid && res.in_holdoff && (res.open_alert || res.delete_alert))
  `WEAC_NEVER(a_alert_xor_supp, clk, rst, res_valid && res.open_alert && res.open_suppressed)

endmodule

FILE: hw/rtl/watch_event_alert_cooldown_core.sv
// Request handling: the holdoff test, then for an opened known key with a nonempty table a scan
//   of the table entries (at most the entries held, so bounded by TABLE_DEPTH), then the result.
// No new request is taken before the last result is through: s_tready is low from accept
//   until the result moves into the output register. The scan is set by the single read port.
// Reset (rst, synchronous): control and config registers return to defaults, the table count
//   clears to zero; table contents are left as they are and never read unwritten.
module watch_event_alert_cooldown_core #(
  parameter int TABLE_DEPTH = weac_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Request stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] event_time, [39:32] watch_index
  input  logic [1:0]  s_tuser,   // [0] opened, [1] deleted
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] in_holdoff, [1] open_alert, [2] open_suppressed,
                                 // [3] delete_alert, [4] key_known, [7:5] zero
  // Register writes.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import weac_pkg::*;

  cfg_t cfg;
  res_t res;
  logic start, idle, res_valid, res_ready;

  // Register file: write only while no request is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cooldown <= COOLDOWN_RST;
      cfg.holdoff <= HOLDOFF_RST;
      cfg.arm_stamp <= ARM_STAMP_RST;
      cfg.watched <= WATCHED_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_COOLDOWN:  cfg.cooldown <= cfg_data[LIM_W-1:0];
        REG_HOLDOFF:   cfg.holdoff <= cfg_data[LIM_W-1:0];
        REG_ARM_STAMP: cfg.arm_stamp <= cfg_data[TIME_W-1:0];
        REG_WATCHED:   cfg.watched <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Take a request only when the sequencer is idle and out of reset.
  assign s_tready = idle && !rst;
  assign start = s_tvalid && s_tready;

  weac_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (start),
    .in_time    (s_tdata[TIME_W-1:0]),
    .in_index   (s_tdata[TIME_W+KEY_W-1:TIME_W]),
    .in_opened  (s_tuser[0]),
    .in_deleted (s_tuser[1]),
    .idle       (idle),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Output register: advance a finished result whenever the slot is empty or draining.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      m_tdata <= {3'b000, res.key_known, res.delete_alert, res.open_suppressed,
                  res.open_alert, res.in_holdoff};
    end
  end

endmodule
